FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

FILE: rtl/core/asd_pkg.sv
// Types and constants shared by the deframer controller, datapath and top level.
package asd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CHAN_W   = 4;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned LO_W     = 7;
    localparam int unsigned HI_W     = 3;
    localparam int unsigned CTR_W    = 32;
    localparam int unsigned MASK_W   = 16;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_MOD   = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted byte
        logic exec;        // decode byte, update flags, counters and store
        logic mod_step;    // one subtract step of the channel wrap
        logic pay_adv;     // commit payload on the advanced channel
        logic line_start;  // count line, clear mask, load first sample
        logic load_next;   // load next sample of the line
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic need_mod;       // payload byte where a header was expected
        logic mod_done;       // wrapped channel value is below the count
        logic line_complete;  // received set equals the active set
        logic out_last;       // sample in the output register ends the line
    } status_t;

endpackage

FILE: rtl/core/asd_if.sv
// Stream and configuration channel interfaces of the deframer.
interface asd_in_if
    import asd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface asd_out_if
    import asd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   sample_channel;
    logic [SAMPLE_W-1:0] sample_value;
    logic                last_in_line;
    logic [CTR_W-1:0]    bytes_seen;
    logic [CTR_W-1:0]    header_errors;
    logic [CTR_W-1:0]    payload_errors;
    logic [CTR_W-1:0]    sanity_errors;
    logic [CTR_W-1:0]    unknown_errors;
    logic [CTR_W-1:0]    lines_done;
    logic [CTR_W-1:0]    samples_done;

    modport source (
        output valid, output sample_channel, output sample_value, output last_in_line,
        output bytes_seen, output header_errors, output payload_errors,
        output sanity_errors, output unknown_errors, output lines_done,
        output samples_done, input ready
    );
    modport sink (
        input valid, input sample_channel, input sample_value, input last_in_line,
        input bytes_seen, input header_errors, input payload_errors,
        input sanity_errors, input unknown_errors, input lines_done,
        input samples_done, output ready
    );
endinterface

interface asd_cfg_if
    import asd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] channel_count;

    modport source (output valid, output channel_count, input ready);
    modport sink   (input valid, input channel_count, output ready);
endinterface

FILE: rtl/core/asd_ctrl.sv
// Deframer controller: sequences byte decode, channel wrap and line emission.
module asd_ctrl
    import asd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.need_mod ? ST_MOD : ST_CHECK;
            end
            ST_MOD:
            begin
                if (status.mod_done)
                begin
                    cmd.pay_adv = 1'b1;
                    state_next  = ST_CHECK;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (status.line_complete)
                begin
                    cmd.line_start = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.load_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/asd_datapath.sv
// Deframer datapath: flags, channel tracking, sample store, counters, output register.
module asd_datapath
    import asd_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic                cfg_valid,
    input  logic [COUNT_W-1:0]  cfg_channel_count,
    output logic [CHAN_W-1:0]   sample_channel,
    output logic [SAMPLE_W-1:0] sample_value,
    output logic                last_in_line,
    output logic [CTR_W-1:0]    bytes_seen,
    output logic [CTR_W-1:0]    header_errors,
    output logic [CTR_W-1:0]    payload_errors,
    output logic [CTR_W-1:0]    sanity_errors,
    output logic [CTR_W-1:0]    unknown_errors,
    output logic [CTR_W-1:0]    lines_done,
    output logic [CTR_W-1:0]    samples_done
);

    localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_CHANNELS);

    // Configuration and control state
    logic [COUNT_W-1:0]  chan_count_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic                expect_hdr_reg, expect_hdr_next;
    logic                idx_pend_reg, idx_pend_next;
    logic [CHAN_W-1:0]   cur_chan_reg, cur_chan_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic [COUNT_W-1:0]  mod_reg, mod_next;
    logic [COUNT_W-1:0]  out_idx_reg;

    // Sample store, split into high and low parts so each is written alone
    logic [HI_W-1:0]     hi_reg [MAX_CHANNELS];
    logic [LO_W-1:0]     lo_reg [MAX_CHANNELS];

    // Counters
    logic [CTR_W-1:0]    bytes_reg, hdr_err_reg, pay_err_reg, san_err_reg;
    logic [CTR_W-1:0]    unk_err_reg, lines_reg, samples_reg;

    // Output register
    logic [CHAN_W-1:0]   out_chan_reg;
    logic [SAMPLE_W-1:0] out_val_reg;
    logic                out_last_reg;

    // Combinational helpers
    logic [COUNT_W-1:0]  active_cnt;
    logic [MASK_W-1:0]   all_mask;
    logic [CHAN_W-1:0]   hdr_chan;
    logic                hdr_ok;
    logic                hi_we, lo_we;
    logic [CHAN_W-1:0]   lo_idx;
    logic                inc_bytes, inc_hdr, inc_pay, inc_san, inc_unk, inc_line, inc_samp;

    // Effective channel count, clamped to 1..MAX_CHANNELS
    always_comb
    begin
        if (chan_count_reg == '0)
        begin
            active_cnt = COUNT_W'(1);
        end
        else if (chan_count_reg > MAX_CNT)
        begin
            active_cnt = MAX_CNT;
        end
        else
        begin
            active_cnt = chan_count_reg;
        end
    end

    // Set of active channels
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            all_mask[i] = (COUNT_W'(i) < active_cnt);
        end
    end

    assign hdr_chan = byte_reg[6:3];
    assign hdr_ok   = ({1'b0, hdr_chan} < active_cnt);

    assign status.need_mod      = !byte_reg[7] && expect_hdr_reg && !idx_pend_reg;
    assign status.mod_done      = (mod_reg < active_cnt);
    assign status.line_complete = (mask_reg == all_mask);
    assign status.out_last      = out_last_reg;

    // Decode and next-state logic
    always_comb
    begin
        expect_hdr_next = expect_hdr_reg;
        idx_pend_next   = idx_pend_reg;
        cur_chan_next   = cur_chan_reg;
        mask_next       = mask_reg;
        mod_next        = mod_reg;
        hi_we           = 1'b0;
        lo_we           = 1'b0;
        lo_idx          = cur_chan_reg;
        inc_bytes       = 1'b0;
        inc_hdr         = 1'b0;
        inc_pay         = 1'b0;
        inc_san         = 1'b0;
        inc_unk         = 1'b0;
        inc_line        = 1'b0;
        inc_samp        = 1'b0;

        if (cmd.exec)
        begin
            inc_bytes = 1'b1;
            if (byte_reg[7])
            begin
                // header byte
                if (expect_hdr_reg && idx_pend_reg)
                begin
                    inc_unk = 1'b1;
                end
                else if (!expect_hdr_reg && idx_pend_reg)
                begin
                    mask_next = mask_reg | (MASK_W'(1) << cur_chan_reg);
                    inc_pay   = 1'b1;
                end
                else if (!expect_hdr_reg && !idx_pend_reg)
                begin
                    inc_unk = 1'b1;
                end
                if (hdr_ok)
                begin
                    cur_chan_next = hdr_chan;
                    hi_we         = 1'b1;
                end
                else
                begin
                    inc_san = 1'b1;
                end
                idx_pend_next   = hdr_ok;
                expect_hdr_next = 1'b0;
            end
            else if (expect_hdr_reg && !idx_pend_reg)
            begin
                // missing header: advance channel, commit after the wrap
                inc_hdr  = 1'b1;
                mod_next = {1'b0, cur_chan_reg} + COUNT_W'(1);
            end
            else
            begin
                // payload byte, channel unchanged
                if (expect_hdr_reg && idx_pend_reg)
                begin
                    inc_unk = 1'b1;
                end
                else if (!expect_hdr_reg && idx_pend_reg)
                begin
                    idx_pend_next = 1'b0;
                    inc_samp      = 1'b1;
                end
                else
                begin
                    idx_pend_next = 1'b1;
                end
                mask_next       = mask_reg | (MASK_W'(1) << cur_chan_reg);
                lo_we           = 1'b1;
                expect_hdr_next = 1'b1;
            end
        end

        if (cmd.mod_step)
        begin
            mod_next = mod_reg - active_cnt;
        end

        if (cmd.pay_adv)
        begin
            cur_chan_next   = mod_reg[CHAN_W-1:0];
            mask_next       = mask_reg | (MASK_W'(1) << mod_reg[CHAN_W-1:0]);
            lo_idx          = mod_reg[CHAN_W-1:0];
            lo_we           = 1'b1;
            expect_hdr_next = 1'b1;
        end

        if (cmd.line_start)
        begin
            inc_line  = 1'b1;
            mask_next = '0;
        end
    end

    // Control registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= COUNT_W'(1);
            expect_hdr_reg <= 1'b0;
            idx_pend_reg   <= 1'b0;
            cur_chan_reg   <= '0;
            mask_reg       <= '0;
            mod_reg        <= '0;
            out_idx_reg    <= '0;
            bytes_reg      <= '0;
            hdr_err_reg    <= '0;
            pay_err_reg    <= '0;
            san_err_reg    <= '0;
            unk_err_reg    <= '0;
            lines_reg      <= '0;
            samples_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                chan_count_reg <= cfg_channel_count;
            end
            expect_hdr_reg <= expect_hdr_next;
            idx_pend_reg   <= idx_pend_next;
            cur_chan_reg   <= cur_chan_next;
            mask_reg       <= mask_next;
            mod_reg        <= mod_next;
            if (cmd.line_start)
            begin
                out_idx_reg <= COUNT_W'(1);
            end
            else if (cmd.load_next)
            begin
                out_idx_reg <= out_idx_reg + COUNT_W'(1);
            end
            bytes_reg   <= bytes_reg   + CTR_W'(inc_bytes);
            hdr_err_reg <= hdr_err_reg + CTR_W'(inc_hdr);
            pay_err_reg <= pay_err_reg + CTR_W'(inc_pay);
            san_err_reg <= san_err_reg + CTR_W'(inc_san);
            unk_err_reg <= unk_err_reg + CTR_W'(inc_unk);
            lines_reg   <= lines_reg   + CTR_W'(inc_line);
            samples_reg <= samples_reg + CTR_W'(inc_samp);
        end
    end

    // Sample store, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                hi_reg[i] <= '0;
                lo_reg[i] <= '0;
            end
        end
        else
        begin
            if (hi_we)
            begin
                hi_reg[hdr_chan[IDX_W-1:0]] <= byte_reg[HI_W-1:0];
            end
            if (lo_we)
            begin
                lo_reg[lo_idx[IDX_W-1:0]] <= byte_reg[LO_W-1:0];
            end
        end
    end

    // Input byte and output sample registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= rx_byte;
        end
        if (cmd.line_start)
        begin
            out_chan_reg <= '0;
            out_val_reg  <= {hi_reg[0], lo_reg[0]};
            out_last_reg <= (active_cnt == COUNT_W'(1));
        end
        else if (cmd.load_next)
        begin
            out_chan_reg <= out_idx_reg[CHAN_W-1:0];
            out_val_reg  <= {hi_reg[out_idx_reg[IDX_W-1:0]], lo_reg[out_idx_reg[IDX_W-1:0]]};
            out_last_reg <= ((out_idx_reg + COUNT_W'(1)) == active_cnt);
        end
    end

    assign sample_channel = out_chan_reg;
    assign sample_value   = out_val_reg;
    assign last_in_line   = out_last_reg;
    assign bytes_seen     = bytes_reg;
    assign header_errors  = hdr_err_reg;
    assign payload_errors = pay_err_reg;
    assign sanity_errors  = san_err_reg;
    assign unknown_errors = unk_err_reg;
    assign lines_done     = lines_reg;
    assign samples_done   = samples_reg;

endmodule

FILE: rtl/core/adc_sample_stream_deframer_unit.sv
// Top level of the ADC sample stream deframer. The block takes one received link byte per
// transaction on rx: a byte with bit 7 set is a header naming a channel and the top three
// sample bits, any other byte carries the low seven bits. Once every active channel
// (channel_count, clamped to 1..MAX_CHANNELS) has been received, the whole line goes out on
// samples, one transaction per channel in ascending order with last_in_line on the final one,
// each carrying the wrapping 32-bit byte, error, line and sample counters. Each byte passes
// through the accept, decode and line check states. A payload byte that arrives where a
// header was expected wraps the channel by repeated subtraction in the datapath, one step
// per cycle. A completed line is emitted while samples.ready is high and holds while it is low.
// rx is not ready again until the line has been taken. The sample store is cleared directly
// by reset, so there is no clearing pass. Configuration writes are taken in any cycle.
`include "assert_macros.svh"

module adc_sample_stream_deframer_unit
    import asd_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = 16
)
(
    input logic      clk,
    input logic      rst_n,
    asd_in_if.sink   rx,
    asd_out_if.source samples,
    asd_cfg_if.sink  cfg
);

    cmd_t    cmd;
    status_t status;
    logic    in_ready;
    logic    out_valid;

    assign cfg.ready     = 1'b1;
    assign rx.ready      = in_ready;
    assign samples.valid = out_valid;

    // Controller
    asd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (samples.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    asd_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .rx_byte           (rx.rx_byte),
        .cfg_valid         (cfg.valid),
        .cfg_channel_count (cfg.channel_count),
        .sample_channel    (samples.sample_channel),
        .sample_value      (samples.sample_value),
        .last_in_line      (samples.last_in_line),
        .bytes_seen        (samples.bytes_seen),
        .header_errors     (samples.header_errors),
        .payload_errors    (samples.payload_errors),
        .sanity_errors     (samples.sanity_errors),
        .unknown_errors    (samples.unknown_errors),
        .lines_done        (samples.lines_done),
        .samples_done      (samples.samples_done)
    );

    // Checks
    `ASSERT_NEVER(a_no_overlap, clk, rst_n, rx.ready && samples.valid, "rx ready during line output")
    `ASSERT_CLK(a_cmd_onehot, clk, rst_n, $onehot0(cmd), "more than one datapath command")
    `ASSERT_CLK(a_last_ends, clk, rst_n, samples.valid && samples.ready && samples.last_in_line |=> !samples.valid, "output continues after last sample")
    `ASSERT_CLK(a_chan_seq, clk, rst_n, samples.valid && samples.ready && !samples.last_in_line |=> samples.valid && (samples.sample_channel == $past(samples.sample_channel) + 4'd1), "sample channels out of order")

endmodule
